// ===== rtl/core/pwm_pdc_pkg.sv =====
// shared types and constants for the pwm period and duty calculator
package pwm_pdc_pkg;

    // field widths of the stream words
    localparam int FIELD_W       = 16;
    localparam int HZ_W          = 32;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 56;

    // default counter width and divider operand width
    localparam int DEF_COUNTER_BITS = 16;
    localparam int DIVISOR_W        = 32;
    localparam int DEF_DVD_W        = DEF_COUNTER_BITS + FIELD_W + 1;

    // arithmetic constants
    localparam logic [FIELD_W-1:0] PRESCALE_MAX = 16'hFFFF;
    localparam int                 PERMILLE     = 1000;

    // command codes carried on s_tuser
    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_DUTY = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_P,
        ST_DIV_R,
        ST_MLOAD,
        ST_MUL,
        ST_DIV_C,
        ST_FIN
    } pdc_state_t;

endpackage

// ===== rtl/core/pwm_pdc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module pwm_pdc_div
    import pwm_pdc_pkg::*;
#(
    parameter int DVD_W = DEF_DVD_W,
    parameter int DSR_W = DIVISOR_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;

    logic [DSR_W:0]   trial;
    logic             ge;
    logic [DSR_W:0]   diff;
    logic [DSR_W-1:0] rem_next;
    logic [DVD_W-1:0] dvd_next;

    // trial subtract of the next dividend bit
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = trial >= {1'b0, dsr_reg};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], ge};
    end

    // control: count one step per cycle, flag done after the last step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift into the dividend register
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== rtl/core/pwm_period_duty_calc.sv =====
// pwm prescaler, reload and compare calculator with a shared serial divider
//
//  channel | dir | word                                   | handshake
//  s_      | in  | tuser: command; tdata: clock,freq,duty | s_tvalid / s_tready
//  m_      | out | tdata: applied,prescale,reload,compare | m_tvalid / m_tready
//
// init word: four serial divisions plus a 16-step shift-add multiply.
// duty word: one multiply and one division; init word with zero frequency: no arithmetic.
// one word in flight; a finished word waits in the output register while
// s_tready comes back, and a new result waits for m_tready before commit.
// reset (aresetn low, synchronous) sets prescale 0, reload all ones, compare 0.
module pwm_period_duty_calc
    import pwm_pdc_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] timer_clock_hz, [63:32] pwm_frequency_hz, [79:64] duty_thousandths
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] command
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] applied, [16:1] prescale_minus_one, [32:17] reload_value,
    // [48:33] compare_value, [55:49] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PROD_W = COUNTER_BITS + FIELD_W + 1;
    localparam int DVD_W  = (PROD_W > DIVISOR_W) ? PROD_W : DIVISOR_W;
    localparam int MCNT_W = $clog2(FIELD_W);
    localparam int CB     = COUNTER_BITS;
    localparam logic [HZ_W:0] RELOAD_MAX = (33'd1 << CB) - 33'd1;

    pdc_state_t state_reg, state_next;

    // stored settings
    logic [FIELD_W-1:0] prescale_reg;
    logic [CB-1:0]      reload_reg;
    logic [CB-1:0]      compare_reg;

    // working copies and latched input word
    logic               applied_reg;
    logic [HZ_W-1:0]    clk_hz_reg;
    logic [HZ_W-1:0]    freq_hz_reg;
    logic [FIELD_W-1:0] duty_reg;
    logic [FIELD_W-1:0] presc_w_reg;
    logic [CB-1:0]      reload_w_reg;
    logic [CB-1:0]      cmp_w_reg;
    logic [HZ_W-1:0]    tmp_reg;

    // serial multiplier
    logic [PROD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  mcand_reg;
    logic [FIELD_W-1:0] mplier_reg;
    logic [MCNT_W-1:0]  mcnt_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // divider hookup
    logic                 start_reg;
    logic                 div_launch;
    logic [DVD_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DVD_W-1:0]     div_quo;

    logic                 accept;
    logic                 fin_fire;
    logic [FIELD_W:0]     presc_full;
    logic [HZ_W-1:0]      q_shift;
    logic [FIELD_W-1:0]   presc_m1;
    logic [HZ_W-1:0]      reload_raw;
    logic [HZ_W-1:0]      reload_m1;
    logic [CB-1:0]        reload_clamp;
    logic [CB-1:0]        cmp_clamp;

    logic [HZ_W-1:0]      in_clk;
    logic [HZ_W-1:0]      in_freq;
    logic [FIELD_W-1:0]   in_duty;

    assign in_clk  = s_tdata[HZ_W-1:0];
    assign in_freq = s_tdata[2*HZ_W-1:HZ_W];
    assign in_duty = s_tdata[2*HZ_W+FIELD_W-1:2*HZ_W];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == CMD_DUTY) begin
                        state_next = ST_MLOAD;
                    end else if (in_freq == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_DIV_Q;
                    end
                end
            end
            ST_DIV_Q: if (div_done) state_next = ST_DIV_P;
            ST_DIV_P: if (div_done) state_next = ST_DIV_R;
            ST_DIV_R: if (div_done) state_next = ST_MLOAD;
            ST_MLOAD: state_next = ST_MUL;
            ST_MUL: begin
                if (mcnt_reg == MCNT_W'(FIELD_W - 1)) state_next = ST_DIV_C;
            end
            ST_DIV_C: if (div_done) state_next = ST_FIN;
            ST_FIN: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs and divider operand select
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        fin_fire     = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
        div_launch   = (state_next != state_reg) &&
                       (state_next == ST_DIV_Q || state_next == ST_DIV_P ||
                        state_next == ST_DIV_R || state_next == ST_DIV_C);
        div_dividend = DVD_W'(clk_hz_reg);
        div_divisor  = freq_hz_reg;
        unique case (state_reg)
            ST_DIV_P: div_divisor = DIVISOR_W'(presc_full);
            ST_DIV_R: div_dividend = DVD_W'(tmp_reg);
            ST_DIV_C: begin
                div_dividend = DVD_W'(acc_reg);
                div_divisor  = DIVISOR_W'(PERMILLE);
            end
            default: begin
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // prescaler from the first quotient, saturated to 16 bits
    always_comb begin
        presc_full = {1'b0, presc_w_reg} + (FIELD_W+1)'(1);
        q_shift    = div_quo[HZ_W-1:0] >> CB;
        presc_m1   = (|q_shift[HZ_W-1:FIELD_W]) ? PRESCALE_MAX : q_shift[FIELD_W-1:0];
    end

    // reload: floor at one before taking one off, then clamp; compare: clamp to reload
    always_comb begin
        reload_raw   = div_quo[HZ_W-1:0];
        reload_m1    = (reload_raw == '0) ? '0 : reload_raw - HZ_W'(1);
        reload_clamp = ({1'b0, reload_m1} > RELOAD_MAX) ? RELOAD_MAX[CB-1:0]
                                                        : reload_m1[CB-1:0];
        cmp_clamp    = (div_quo > DVD_W'(reload_w_reg)) ? reload_w_reg
                                                        : div_quo[CB-1:0];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            prescale_reg <= '0;
            reload_reg   <= RELOAD_MAX[CB-1:0];
            compare_reg  <= '0;
        end else begin
            state_reg <= state_next;
            start_reg <= div_launch;
            if (fin_fire) begin
                m_tvalid_reg <= 1'b1;
                prescale_reg <= presc_w_reg;
                reload_reg   <= reload_w_reg;
                compare_reg  <= cmp_w_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            applied_reg  <= !(s_tuser == CMD_INIT && in_freq == '0);
            clk_hz_reg   <= in_clk;
            freq_hz_reg  <= in_freq;
            duty_reg     <= in_duty;
            presc_w_reg  <= prescale_reg;
            reload_w_reg <= reload_reg;
            cmp_w_reg    <= compare_reg;
        end
        if (div_done) begin
            case (state_reg)
                ST_DIV_Q: presc_w_reg  <= presc_m1;
                ST_DIV_P: tmp_reg      <= div_quo[HZ_W-1:0];
                ST_DIV_R: reload_w_reg <= reload_clamp;
                ST_DIV_C: cmp_w_reg    <= cmp_clamp;
                default: begin
                end
            endcase
        end
        // shift-add multiply of duty by reload plus one
        if (state_reg == ST_MLOAD) begin
            acc_reg    <= '0;
            mcand_reg  <= PROD_W'(reload_w_reg) + PROD_W'(1);
            mplier_reg <= duty_reg;
            mcnt_reg   <= '0;
        end else if (state_reg == ST_MUL) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            mcnt_reg   <= mcnt_reg + MCNT_W'(1);
        end
        // result word
        if (fin_fire) begin
            m_tdata_reg <= {7'b0, FIELD_W'(cmp_w_reg), FIELD_W'(reload_w_reg),
                            presc_w_reg, applied_reg};
        end
    end

    pwm_pdc_div #(
        .DVD_W (DVD_W),
        .DSR_W (DIVISOR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/pwm_pdc_chk.sv =====
// port-level checks for the pwm period and duty calculator, bound to the top
module pwm_pdc_chk
    import pwm_pdc_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    // compare never above reload when the fields show the whole counter
    a_cmp_le_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (COUNTER_BITS <= FIELD_W) |-> m_tdata[48:33] <= m_tdata[32:17])
        else $error("compare above reload");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pwm_period_duty_calc pwm_pdc_chk #(
    .COUNTER_BITS (COUNTER_BITS)
) u_pdc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
